>>> rtl/global_alignment_best_cell_core_defines.svh
// Assertion macros for the global alignment best cell core.
`ifndef GLOBAL_ALIGNMENT_BEST_CELL_CORE_DEFINES_SVH
`define GLOBAL_ALIGNMENT_BEST_CELL_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// pre holds at an edge: post holds at the same edge
`define GABC_ASSERT_IMP(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("gabc: same-cycle check failed");

// pre holds at an edge: post holds at the next edge
`define GABC_ASSERT_NXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("gabc: next-cycle check failed");

`else

`define GABC_ASSERT_IMP(name, clk, rst_n, pre, post)
`define GABC_ASSERT_NXT(name, clk, rst_n, pre, post)

`endif

`endif

>>> rtl/gabc_pkg.sv
`timescale 1ns / 1ps

package gabc_pkg;

	localparam int MAX_LEN_DEF = 64;

	localparam logic [1:0] CFG_MATCH    = 2'd0;
	localparam logic [1:0] CFG_MISMATCH = 2'd1;
	localparam logic [1:0] CFG_GAP      = 2'd2;

	localparam logic signed [4:0] MATCH_RST    = 5'sd2;
	localparam logic signed [4:0] MISMATCH_RST = -5'sd6;
	localparam logic signed [4:0] GAP_RST      = -5'sd4;

	typedef struct packed {
		logic       mode;
		logic [7:0] base;
		logic       last;
	} in_t;

	typedef struct packed {
		logic [6:0]  best_row;
		logic [6:0]  best_column;
		logic [11:0] best_score;
		logic        overflow;
	} out_t;

	// query row traveling down the chain
	typedef struct packed {
		logic       v;
		logic       last;
		logic [7:0] q;
	} lane_t;

	// broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic              start;
		logic              ref_we;
		logic [7:0]        ref_base;
		logic signed [4:0] match;
		logic signed [4:0] mismatch;
		logic signed [4:0] gap;
	} ctl_t;

endpackage

>>> rtl/gabc_cell.sv
`timescale 1ns / 1ps

module gabc_cell #(
	parameter int J  = 1,
	parameter int IW = 7,
	parameter int SW = 13
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gabc_pkg::ctl_t        ctl,
	input  logic [IW-1:0]         cols,
	input  logic [IW-1:0]         ref_idx,
	input  gabc_pkg::lane_t       lane_in,
	input  logic signed [SW-1:0]  h_in,
	input  logic signed [SW-1:0]  d_in,
	input  logic signed [SW-1:0]  rb_score_in,
	input  logic [IW-1:0]         rb_col_in,
	output gabc_pkg::lane_t       lane_out,
	output logic signed [SW-1:0]  h_out,
	output logic signed [SW-1:0]  d_out,
	output logic signed [SW-1:0]  rb_score_out,
	output logic [IW-1:0]         rb_col_out
);

	localparam logic [IW-1:0]        COL   = IW'(J);
	localparam logic [IW-1:0]        PREV  = IW'(J - 1);
	localparam logic signed [SW-1:0] COL_S = SW'(J);

	logic [7:0]           ref_q;
	logic signed [SW-1:0] up_q;
	gabc_pkg::lane_t      lane_s1;
	logic signed [SW-1:0] h_s1;
	logic signed [SW-1:0] d_s1;
	logic signed [SW-1:0] rb_score_s1;
	logic [IW-1:0]        rb_col_s1;

	logic signed [SW-1:0] match_x;
	logic signed [SW-1:0] mismatch_x;
	logic signed [SW-1:0] gap_x;
	logic signed [SW-1:0] up_init;
	logic signed [SW-1:0] diag;
	logic signed [SW-1:0] from_up;
	logic signed [SW-1:0] from_left;
	logic signed [SW-1:0] h_new;
	logic                 active;
	logic                 take;

	assign match_x    = {{(SW-5){ctl.match[4]}}, ctl.match};
	assign mismatch_x = {{(SW-5){ctl.mismatch[4]}}, ctl.mismatch};
	assign gap_x      = {{(SW-5){ctl.gap[4]}}, ctl.gap};
	assign up_init    = COL_S * gap_x;

	assign diag      = d_in + ((lane_in.q == ref_q) ? match_x : mismatch_x);
	assign from_up   = up_q + gap_x;
	assign from_left = h_in + gap_x;

	always_comb begin
		h_new = diag;
		if (from_up > h_new) begin
			h_new = from_up;
		end
		if (from_left > h_new) begin
			h_new = from_left;
		end
	end

	assign active = (COL <= cols);
	assign take   = active && (h_new > rb_score_in);

	always_ff @(posedge clk) begin
		if (ctl.ref_we && (ref_idx == PREV)) begin
			ref_q <= ctl.ref_base;
		end
		if (ctl.start) begin
			up_q <= up_init;
		end else if (lane_in.v) begin
			up_q <= h_new;
		end
		h_s1        <= h_new;
		d_s1        <= up_q;
		rb_score_s1 <= take ? h_new : rb_score_in;
		rb_col_s1   <= take ? COL : rb_col_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s1 <= '0;
		end else begin
			lane_s1 <= lane_in;
		end
	end

	assign lane_out     = lane_s1;
	assign h_out        = h_s1;
	assign d_out        = d_s1;
	assign rb_score_out = rb_score_s1;
	assign rb_col_out   = rb_col_s1;

endmodule

>>> rtl/global_alignment_best_cell_core.sv
`timescale 1ns / 1ps
// Loading: one item per cycle while in the load state. After the reference item with
// last set, the query rows stream down a chain of MAX_LEN cells, one row per cycle;
// the result is registered once the last row leaves the chain and the output is free.
// Reset: match 2, mismatch -6, gap -4, lengths and overflow cleared, no result pending.
`include "global_alignment_best_cell_core_defines.svh"

module global_alignment_best_cell_core #(
	parameter int MAX_LEN = gabc_pkg::MAX_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gabc_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output gabc_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [4:0]     cfg_data
);

	localparam int IW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int SW = $clog2(32 * MAX_LEN + 1) + 1;
	localparam logic [IW-1:0] LEN_MAX = IW'(MAX_LEN);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t               state_q;
	logic signed [4:0]    match_q;
	logic signed [4:0]    mismatch_q;
	logic signed [4:0]    gap_q;
	logic [IW-1:0]        qlen_q;
	logic [IW-1:0]        rlen_q;
	logic                 ovf_q;
	logic                 start_q;
	logic [IW-1:0]        iss_q;
	logic                 rd_v_s1;
	logic                 rd_last_s1;
	logic [7:0]           q_rd_s1;
	logic signed [SW-1:0] border_q;
	logic [IW-1:0]        row_cnt_q;
	logic signed [SW-1:0] best_q;
	logic [IW-1:0]        best_row_q;
	logic [IW-1:0]        best_col_q;
	logic                 out_valid_q;
	gabc_pkg::out_t       out_data_q;
	logic [7:0]           qmem [MAX_LEN];

	logic                 in_fire;
	logic                 q_we;
	logic                 r_we;
	logic                 issue;
	logic                 emit;
	logic signed [SW-1:0] gap_x;
	logic signed [31:0]   best_w;
	logic [11:0]          score_sat;
	gabc_pkg::ctl_t       ctl;

	gabc_pkg::lane_t      lane     [MAX_LEN+1];
	logic signed [SW-1:0] h        [MAX_LEN+1];
	logic signed [SW-1:0] d        [MAX_LEN+1];
	logic signed [SW-1:0] rb_score [MAX_LEN+1];
	logic [IW-1:0]        rb_col   [MAX_LEN+1];

	assign in_ready  = (state_q == ST_LOAD);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign q_we      = in_fire && !in_data.mode && (qlen_q < LEN_MAX);
	assign r_we      = in_fire && in_data.mode && (rlen_q < LEN_MAX);
	assign issue     = (state_q == ST_RUN) && (iss_q < qlen_q);
	assign emit      = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign gap_x     = {{(SW-5){gap_q[4]}}, gap_q};

	assign best_w    = 32'(best_q);
	assign score_sat = (best_w > 32'sd4095) ? 12'hFFF : best_w[11:0];

	always_comb begin
		ctl          = '0;
		ctl.start    = start_q;
		ctl.ref_we   = r_we;
		ctl.ref_base = in_data.base;
		ctl.match    = match_q;
		ctl.mismatch = mismatch_q;
		ctl.gap      = gap_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q    <= gabc_pkg::MATCH_RST;
			mismatch_q <= gabc_pkg::MISMATCH_RST;
			gap_q      <= gabc_pkg::GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gabc_pkg::CFG_MATCH:    match_q    <= cfg_data;
				gabc_pkg::CFG_MISMATCH: mismatch_q <= cfg_data;
				gabc_pkg::CFG_GAP:      gap_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			qmem[qlen_q[AW-1:0]] <= in_data.base;
		end
		q_rd_s1 <= qmem[iss_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			qlen_q      <= '0;
			rlen_q      <= '0;
			ovf_q       <= 1'b0;
			start_q     <= 1'b0;
			iss_q       <= '0;
			rd_v_s1     <= 1'b0;
			rd_last_s1  <= 1'b0;
			border_q    <= '0;
			row_cnt_q   <= '0;
			best_q      <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			start_q    <= in_fire && in_data.mode && in_data.last;
			rd_v_s1    <= issue;
			rd_last_s1 <= issue && ((iss_q + IW'(1)) == qlen_q);
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (q_we) begin
						qlen_q <= qlen_q + IW'(1);
					end
					if (r_we) begin
						rlen_q <= rlen_q + IW'(1);
					end
					if (in_fire && !q_we && !r_we) begin
						ovf_q <= 1'b1;
					end
					if (in_fire && in_data.mode && in_data.last) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						iss_q <= iss_q + IW'(1);
					end
					if (rd_v_s1) begin
						border_q <= border_q + gap_x;
					end
					if (lane[MAX_LEN].v) begin
						row_cnt_q <= row_cnt_q + IW'(1);
						if (rb_score[MAX_LEN] > best_q) begin
							best_q     <= rb_score[MAX_LEN];
							best_row_q <= row_cnt_q + IW'(1);
							best_col_q <= rb_col[MAX_LEN];
						end
						if (lane[MAX_LEN].last) begin
							state_q <= ST_DONE;
						end
					end
					if (start_q && (qlen_q == '0)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (emit) begin
						out_data_q.best_row    <= 7'(best_row_q);
						out_data_q.best_column <= 7'(best_col_q);
						out_data_q.best_score  <= score_sat;
						out_data_q.overflow    <= ovf_q;
						qlen_q                 <= '0;
						rlen_q                 <= '0;
						ovf_q                  <= 1'b0;
						iss_q                  <= '0;
						border_q               <= '0;
						row_cnt_q              <= '0;
						best_q                 <= '0;
						best_row_q             <= '0;
						best_col_q             <= '0;
						state_q                <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// column 0 border feeds the head of the chain
	assign lane[0]     = {rd_v_s1, rd_last_s1, q_rd_s1};
	assign h[0]        = border_q + gap_x;
	assign d[0]        = border_q;
	assign rb_score[0] = '0;
	assign rb_col[0]   = '0;

	for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
		gabc_cell #(
			.J  (j),
			.IW (IW),
			.SW (SW)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.cols         (rlen_q),
			.ref_idx      (rlen_q),
			.lane_in      (lane[j-1]),
			.h_in         (h[j-1]),
			.d_in         (d[j-1]),
			.rb_score_in  (rb_score[j-1]),
			.rb_col_in    (rb_col[j-1]),
			.lane_out     (lane[j]),
			.h_out        (h[j]),
			.d_out        (d[j]),
			.rb_score_out (rb_score[j]),
			.rb_col_out   (rb_col[j])
		);
	end

	`GABC_ASSERT_IMP(a_tail_only_in_run, clk, arst_n, lane[MAX_LEN].v, state_q == ST_RUN)
	`GABC_ASSERT_IMP(a_issue_bounded, clk, arst_n, 1'b1, iss_q <= qlen_q)
	`GABC_ASSERT_IMP(a_len_bounded, clk, arst_n, 1'b1, (qlen_q <= LEN_MAX) && (rlen_q <= LEN_MAX))
	`GABC_ASSERT_NXT(a_done_waits, clk, arst_n, (state_q == ST_DONE) && !emit, state_q == ST_DONE)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_LEN = gabc_pkg::MAX_LEN_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 2 * MAX_LEN + 32;
	localparam logic MODE_QUERY = 1'b0;
	localparam logic MODE_REF = 1'b1;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [4:0] SCORE_MAX = 5'b01111;
	localparam logic [4:0] SCORE_MIN = 5'b10000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	gabc_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	gabc_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;

	// predictor state
	logic signed [4:0] match_val = gabc_pkg::MATCH_RST;
	logic signed [4:0] mismatch_val = gabc_pkg::MISMATCH_RST;
	logic signed [4:0] gap_val = gabc_pkg::GAP_RST;
	logic [7:0] qry_mem [MAX_LEN];
	logic [7:0] ref_mem [MAX_LEN];
	int qry_len = 0;
	int ref_len = 0;
	bit ovf_flag = 1'b0;
	gabc_pkg::out_t best_cell_q [$];

	int errors = 0;
	int items_sent = 0;
	int hold_left = 0;
	bit no_gap_run = 1'b0;
	int cycles = 0;
	gabc_pkg::out_t want;

	global_alignment_best_cell_core #(.MAX_LEN(MAX_LEN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic gabc_pkg::out_t align_job();
		int row [0:MAX_LEN];
		int best, best_i, best_j, diag, score_v, up_v, left_v;
		int m_s, x_s, g_s, i, j;
		gabc_pkg::out_t res;
		m_s = match_val;
		x_s = mismatch_val;
		g_s = gap_val;
		best = 0;
		best_i = 0;
		best_j = 0;
		for (j = 0; j <= ref_len; j++)
			row[j] = j * g_s;
		for (i = 1; i <= qry_len; i++) begin
			diag = row[0];
			row[0] = i * g_s;
			for (j = 1; j <= ref_len; j++) begin
				up_v = row[j];
				left_v = row[j - 1];
				score_v = diag + ((qry_mem[i - 1] == ref_mem[j - 1]) ? m_s : x_s);
				if (up_v + g_s > score_v)
					score_v = up_v + g_s;
				if (left_v + g_s > score_v)
					score_v = left_v + g_s;
				diag = up_v;
				row[j] = score_v;
				if (score_v > best) begin
					best = score_v;
					best_i = i;
					best_j = j;
				end
			end
		end
		res.best_row = 7'(best_i);
		res.best_column = 7'(best_j);
		res.best_score = (best > 4095) ? 12'd4095 : 12'(best);
		res.overflow = ovf_flag;
		return res;
	endfunction

	function automatic void predict_item(gabc_pkg::in_t it);
		if (it.mode == MODE_QUERY) begin
			if (qry_len < MAX_LEN) begin
				qry_mem[qry_len] = it.base;
				qry_len++;
			end else
				ovf_flag = 1'b1;
		end else begin
			if (ref_len < MAX_LEN) begin
				ref_mem[ref_len] = it.base;
				ref_len++;
			end else
				ovf_flag = 1'b1;
			if (it.last) begin
				best_cell_q = {best_cell_q, align_job()};
				qry_len = 0;
				ref_len = 0;
				ovf_flag = 1'b0;
			end
		end
	endfunction

	function automatic gabc_pkg::in_t mk(logic mode, logic [7:0] base, logic last);
		gabc_pkg::in_t it;
		it.mode = mode;
		it.base = base;
		it.last = last;
		return it;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gap_run)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic int pick_len(bit is_query);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return is_query ? 0 : 1;
		else if (r < 70)
			return $urandom_range(1, 8);
		else if (r < 90)
			return $urandom_range(9, 24);
		else if (r < 97)
			return $urandom_range(25, MAX_LEN);
		else
			return $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
	endfunction

	function automatic logic [4:0] pick_score();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return SCORE_MIN;
		else if (r < 30)
			return SCORE_MAX;
		else
			return 5'($urandom_range(0, 31));
	endfunction

	task automatic send_item(gabc_pkg::in_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		predict_item(it);
		items_sent++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			gabc_pkg::CFG_MATCH: match_val = val;
			gabc_pkg::CFG_MISMATCH: mismatch_val = val;
			gabc_pkg::CFG_GAP: gap_val = val;
			default: ;
		endcase
	endtask

	// drop valid, wait for all pending results, then let the array drain
	task automatic settle_block();
		in_valid <= 1'b0;
		while (best_cell_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_job(int qn, int rn, bit dense);
		gabc_pkg::in_t qs [$];
		gabc_pkg::in_t rs [$];
		gabc_pkg::in_t it;
		logic [7:0] alpha [4];
		bit wide;
		int k;
		wide = ($urandom_range(0, 4) == 0);
		for (k = 0; k < 4; k++)
			alpha[k] = 8'($urandom_range(0, 255));
		for (k = 0; k < qn; k++) begin
			it.mode = MODE_QUERY;
			it.base = wide ? 8'($urandom_range(0, 255)) : alpha[$urandom_range(0, 3)];
			it.last = (k == qn - 1) ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 19) == 0);
			qs = {qs, it};
		end
		for (k = 0; k < rn; k++) begin
			it.mode = MODE_REF;
			it.base = wide ? 8'($urandom_range(0, 255)) : alpha[$urandom_range(0, 3)];
			it.last = (k == rn - 1);
			rs = {rs, it};
		end
		no_gap_run = dense;
		if ($urandom_range(0, 4) == 0) begin
			while (qs.size() > 0 || rs.size() > 1) begin
				if (qs.size() > 0 && (rs.size() <= 1 || $urandom_range(0, 1) == 1))
					send_item(qs.pop_front());
				else
					send_item(rs.pop_front());
			end
		end
		while (qs.size() > 0)
			send_item(qs.pop_front());
		while (rs.size() > 0)
			send_item(rs.pop_front());
	endtask

	task automatic randomize_regs();
		settle_block();
		write_reg(gabc_pkg::CFG_MATCH, pick_score());
		write_reg(gabc_pkg::CFG_MISMATCH, pick_score());
		write_reg(gabc_pkg::CFG_GAP, pick_score());
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_UNUSED, 5'($urandom_range(0, 31)));
	endtask

	task automatic test_reset_defaults();
		// equal extreme bytes on both sides
		send_item(mk(MODE_QUERY, 8'h00, 1'b0));
		send_item(mk(MODE_QUERY, 8'hFF, 1'b1));
		send_item(mk(MODE_REF, 8'h00, 1'b0));
		send_item(mk(MODE_REF, 8'hFF, 1'b1));
		// empty query
		send_item(mk(MODE_REF, 8'h41, 1'b1));
		// single mismatch, nothing beats zero
		send_item(mk(MODE_QUERY, 8'h01, 1'b1));
		send_item(mk(MODE_REF, 8'h02, 1'b1));
		// query last mid-job, query item after reference items
		send_item(mk(MODE_QUERY, 8'h41, 1'b1));
		send_item(mk(MODE_REF, 8'h43, 1'b0));
		send_item(mk(MODE_QUERY, 8'h47, 1'b1));
		send_item(mk(MODE_REF, 8'h41, 1'b1));
	endtask

	task automatic test_config_extremes();
		settle_block();
		write_reg(gabc_pkg::CFG_MATCH, SCORE_MAX);
		write_reg(gabc_pkg::CFG_MISMATCH, SCORE_MIN);
		write_reg(gabc_pkg::CFG_GAP, SCORE_MIN);
		write_reg(CFG_UNUSED, 5'b01010);
		send_item(mk(MODE_QUERY, 8'h41, 1'b0));
		send_item(mk(MODE_QUERY, 8'h42, 1'b1));
		send_item(mk(MODE_REF, 8'h41, 1'b0));
		send_item(mk(MODE_REF, 8'h43, 1'b0));
		send_item(mk(MODE_REF, 8'h42, 1'b1));
		settle_block();
		write_reg(gabc_pkg::CFG_MATCH, SCORE_MIN);
		write_reg(gabc_pkg::CFG_MISMATCH, SCORE_MAX);
		write_reg(gabc_pkg::CFG_GAP, SCORE_MAX);
		send_item(mk(MODE_QUERY, 8'h58, 1'b1));
		send_item(mk(MODE_REF, 8'h59, 1'b0));
		send_item(mk(MODE_REF, 8'h58, 1'b1));
		settle_block();
		write_reg(gabc_pkg::CFG_MATCH, 5'd0);
		write_reg(gabc_pkg::CFG_MISMATCH, 5'd0);
		write_reg(gabc_pkg::CFG_GAP, 5'd0);
		send_item(mk(MODE_QUERY, 8'h41, 1'b1));
		send_item(mk(MODE_REF, 8'h41, 1'b1));
	endtask

	task automatic test_long_sequences();
		randomize_regs();
		run_job(MAX_LEN, MAX_LEN, 1'b0);
		run_job(MAX_LEN + 6, 3, 1'b0);
		run_job(5, MAX_LEN + 4, 1'b0);
		run_job(0, MAX_LEN + 2, 1'b1);
	endtask

	task automatic test_backpressure();
		int k;
		hold_left = 1500;
		for (k = 0; k < 8; k++)
			run_job($urandom_range(3, 6), $urandom_range(3, 6), 1'b1);
	endtask

	task automatic test_random();
		int p, phase_start;
		for (p = 0; p < 5; p++) begin
			randomize_regs();
			phase_start = items_sent;
			while (items_sent - phase_start < 15)
				run_job(pick_len(1'b1), pick_len(1'b0), $urandom_range(0, 3) == 0);
		end
	endtask

	task automatic report_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (best_cell_q.size() == 0) begin
				$display("%0t: unexpected transaction row %0d column %0d score %0d overflow %0d",
					$time, out_data.best_row, out_data.best_column, out_data.best_score,
					out_data.overflow);
				errors++;
			end else begin
				want = best_cell_q.pop_front();
				report_field("best_row", want.best_row, out_data.best_row);
				report_field("best_column", want.best_column, out_data.best_column);
				report_field("best_score", want.best_score, out_data.best_score);
				report_field("overflow", want.overflow, out_data.overflow);
			end
		end
	end

	initial begin
		int run_left;
		int len;
		int r;
		logic level;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					level = 1'b1;
					len = $urandom_range(1, 20);
				end else if (r < 55) begin
					level = 1'b1;
					len = $urandom_range(100, 300);
				end else if (r < 85) begin
					level = 1'b0;
					len = $urandom_range(1, 3);
				end else if (r < 96) begin
					level = 1'b0;
					len = $urandom_range(4, 15);
				end else begin
					level = 1'b0;
					len = $urandom_range(20, 60);
				end
				out_ready <= level;
				run_left = len - 1;
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout", $time);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_long_sequences();
		test_backpressure();
		test_random();
		settle_block();
		if (best_cell_q.size() != 0) begin
			want = best_cell_q[0];
			$display("%0t: missing transaction row %0d column %0d score %0d overflow %0d",
				$time, want.best_row, want.best_column, want.best_score, want.overflow);
			errors++;
		end
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
